/* rtl/assert_macros.svh */
// Assertion macros for the checker module of this project.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, checked out of reset.
`define ASSERT_IMPL(name, clk, rst_n, ante, cons) \
  name: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
    else $error("assertion failed");

// Next-cycle implication, checked out of reset.
`define ASSERT_NEXT(name, clk, rst_n, ante, cons) \
  name: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

/* rtl/ilt_pkg.sv */
// Types, codes and default sizes of the indentation level tracker.
package ilt_pkg;

  localparam int DEF_MAX_LEVELS    = 64;
  localparam int DEF_TAB_WIDTH     = 8;
  localparam int DEF_ALT_TAB_WIDTH = 1;
  localparam int DEF_COL_BITS      = 16;

  localparam int CP_W    = 21;
  localparam int COUNT_W = 7;
  localparam int DEPTH_W = 6;

  localparam logic [CP_W-1:0] CP_SPACE   = 21'h00020;
  localparam logic [CP_W-1:0] CP_TAB     = 21'h00009;
  localparam logic [CP_W-1:0] CP_NEWLINE = 21'h0000A;

  typedef enum logic [1:0] {
    KIND_SAME   = 2'd0,
    KIND_INDENT = 2'd1,
    KIND_DEDENT = 2'd2
  } kind_t;

  typedef enum logic [2:0] {
    STAT_OK             = 3'd0,
    STAT_ALT_SAME       = 3'd1,
    STAT_TOO_DEEP       = 3'd2,
    STAT_ALT_NOT_DEEPER = 3'd3,
    STAT_NO_MATCH       = 3'd4,
    STAT_ALT_DEDENT     = 3'd5,
    STAT_READ_ERROR     = 3'd6
  } status_t;

  typedef enum logic {
    ST_ACCEPT = 1'b0,
    ST_POP    = 1'b1
  } state_t;

endpackage

/* rtl/ilt_ram.sv */
// Generic single-port-write, single-port-read RAM with registered read data.
module ilt_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

/* rtl/indent_level_tracker_core.sv */
// Top level of the indentation level tracker: line measure, level stack and result register.
//
//  channel | direction | transaction
//  --------+-----------+-------------------------------------------------------
//  in_     | input     | one grapheme: code point in tdata, flags in tuser
//  out_    | output    | one result per line: kind in tuser, count/status/depth
//
// Cycles: one grapheme per cycle while measuring or skipping and the result
// register is free or being taken. A line that closes levels holds off input
// during the pop walk over the registered-read level stack memory (one stack entry read a cycle).
// Reset: rst_n is synchronous; stack entry zero is held as column 0 by logic,
// so there is no clearing pass. Stalls: in_tready drops while the result
// register is full and not being taken, and during the level pop walk.
module indent_level_tracker_core #(
  parameter int MAX_LEVELS    = ilt_pkg::DEF_MAX_LEVELS,
  parameter int TAB_WIDTH     = ilt_pkg::DEF_TAB_WIDTH,
  parameter int ALT_TAB_WIDTH = ilt_pkg::DEF_ALT_TAB_WIDTH,
  parameter int COL_BITS      = ilt_pkg::DEF_COL_BITS
) (
  input  logic        clk,
  input  logic        rst_n,
  // in_tdata: [20:0] code_point, [23:21] zero
  input  logic [23:0] in_tdata,
  // in_tuser: [0] multi_point, [1] read_error
  input  logic [1:0]  in_tuser,
  input  logic        in_tvalid,
  output logic        in_tready,
  // out_tdata: [6:0] change_count, [9:7] status, [15:10] depth_after
  output logic [15:0] out_tdata,
  // out_tuser: [1:0] change_kind
  output logic [1:0]  out_tuser,
  output logic        out_tvalid,
  input  logic        out_tready
);

  localparam int AW   = $clog2(MAX_LEVELS);
  localparam int CMW  = (TAB_WIDTH > 1) ? $clog2(TAB_WIDTH) : 1;
  localparam int AMW  = (ALT_TAB_WIDTH > 1) ? $clog2(ALT_TAB_WIDTH) : 1;
  localparam int TSW  = $clog2(TAB_WIDTH + 1);
  localparam int ATSW = $clog2(ALT_TAB_WIDTH + 1);
  localparam logic [COL_BITS-1:0] COL_MAX = '1;
  localparam logic [AW-1:0] TOP_LEVEL = AW'(MAX_LEVELS - 1);

  // Input fields
  logic [ilt_pkg::CP_W-1:0] code_point;
  logic multi_point, read_error;
  logic is_space, is_tab, is_newline, in_acc;

  assign code_point  = in_tdata[ilt_pkg::CP_W-1:0];
  assign multi_point = in_tuser[0];
  assign read_error  = in_tuser[1];
  assign is_space    = !multi_point && (code_point == ilt_pkg::CP_SPACE);
  assign is_tab      = !multi_point && (code_point == ilt_pkg::CP_TAB);
  assign is_newline  = !multi_point && (code_point == ilt_pkg::CP_NEWLINE);

  // State
  ilt_pkg::state_t state_r, state_nxt;
  logic                col_r, col_dummy_unused;
  logic [COL_BITS-1:0] column_r, column_nxt;
  logic [COL_BITS-1:0] alt_col_r, alt_col_nxt;
  logic [CMW-1:0]      cmod_r, cmod_nxt;     // column mod TAB_WIDTH
  logic [AMW-1:0]      amod_r, amod_nxt;     // alt column mod ALT_TAB_WIDTH
  logic                skip_r, skip_nxt;
  logic [AW-1:0]       level_r, level_nxt;
  logic [COL_BITS-1:0] top_col_r, top_col_nxt;  // mirror of stack[level]
  logic [COL_BITS-1:0] top_alt_r, top_alt_nxt;
  logic [AW-1:0]       lv_r, lv_nxt;            // entry under test in the pop walk
  logic                rd_zero_r, rd_zero_nxt;  // read targets entry zero

  // Result register
  logic                 out_valid_r, out_valid_nxt;
  ilt_pkg::kind_t       out_kind_r, out_kind_nxt;
  logic [ilt_pkg::COUNT_W-1:0] out_count_r, out_count_nxt;
  ilt_pkg::status_t     out_status_r, out_status_nxt;
  logic [ilt_pkg::DEPTH_W-1:0] out_depth_r, out_depth_nxt;

  // Stack memory: {alt column, column} per level
  logic                  ram_we, ram_re;
  logic [AW-1:0]         ram_waddr, ram_raddr;
  logic [2*COL_BITS-1:0] ram_wdata, ram_rdata;
  logic [COL_BITS-1:0]   rd_col, rd_alt;

  ilt_ram #(
    .WIDTH (2 * COL_BITS),
    .DEPTH (MAX_LEVELS)
  ) u_stack (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (ram_re),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  // Entry zero is never written; it always reads as column 0.
  assign rd_col = rd_zero_r ? '0 : ram_rdata[COL_BITS-1:0];
  assign rd_alt = rd_zero_r ? '0 : ram_rdata[2*COL_BITS-1:COL_BITS];

  // Measure arithmetic: a tab adds the distance to the next stop, kept
  // incrementally through the mod counters. Past saturation the mod value
  // no longer matters since any step overflows to COL_MAX again.
  logic [COL_BITS-1:0] col_space, alt_space, col_tab, alt_tab;
  logic [COL_BITS:0]   col_tab_sum, alt_tab_sum;
  logic [CMW-1:0]      cmod_space;
  logic [AMW-1:0]      amod_space;

  always_comb begin
    col_space   = (column_r == COL_MAX) ? column_r : column_r + 1'b1;
    alt_space   = (alt_col_r == COL_MAX) ? alt_col_r : alt_col_r + 1'b1;
    col_tab_sum = {1'b0, column_r}
                + (COL_BITS+1)'(TSW'(TAB_WIDTH) - TSW'(cmod_r));
    alt_tab_sum = {1'b0, alt_col_r}
                + (COL_BITS+1)'(ATSW'(ALT_TAB_WIDTH) - ATSW'(amod_r));
    col_tab     = col_tab_sum[COL_BITS] ? COL_MAX : col_tab_sum[COL_BITS-1:0];
    alt_tab     = alt_tab_sum[COL_BITS] ? COL_MAX : alt_tab_sum[COL_BITS-1:0];
    cmod_space  = (cmod_r == CMW'(TAB_WIDTH - 1)) ? '0 : cmod_r + 1'b1;
    amod_space  = (amod_r == AMW'(ALT_TAB_WIDTH - 1)) ? '0 : amod_r + 1'b1;
  end

  assign in_tready = (state_r == ilt_pkg::ST_ACCEPT) && (!out_valid_r || out_tready);
  assign in_acc    = in_tvalid && in_tready;

  // Next state, stack access and result
  always_comb begin
    state_nxt      = state_r;
    column_nxt     = column_r;
    alt_col_nxt    = alt_col_r;
    cmod_nxt       = cmod_r;
    amod_nxt       = amod_r;
    skip_nxt       = skip_r;
    level_nxt      = level_r;
    top_col_nxt    = top_col_r;
    top_alt_nxt    = top_alt_r;
    lv_nxt         = lv_r;
    rd_zero_nxt    = rd_zero_r;
    out_valid_nxt  = out_valid_r && !out_tready;
    out_kind_nxt   = out_kind_r;
    out_count_nxt  = out_count_r;
    out_status_nxt = out_status_r;
    out_depth_nxt  = out_depth_r;
    ram_we         = 1'b0;
    ram_waddr      = level_r + 1'b1;
    ram_wdata      = {alt_col_r, column_r};
    ram_re         = 1'b0;
    ram_raddr      = level_r - 1'b1;

    case (state_r)
      ilt_pkg::ST_ACCEPT: begin
        if (in_acc) begin
          if (read_error) begin
            // decoder error or end of input: report and start a fresh line
            column_nxt     = '0;
            alt_col_nxt    = '0;
            cmod_nxt       = '0;
            amod_nxt       = '0;
            skip_nxt       = 1'b0;
            out_valid_nxt  = 1'b1;
            out_kind_nxt   = ilt_pkg::KIND_SAME;
            out_count_nxt  = '0;
            out_status_nxt = ilt_pkg::STAT_READ_ERROR;
            out_depth_nxt  = ilt_pkg::DEPTH_W'(level_r);
          end else if (skip_r) begin
            if (is_newline) begin
              skip_nxt = 1'b0;
            end
          end else if (is_space) begin
            column_nxt  = col_space;
            alt_col_nxt = alt_space;
            cmod_nxt    = cmod_space;
            amod_nxt    = amod_space;
          end else if (is_tab) begin
            column_nxt  = col_tab;
            alt_col_nxt = alt_tab;
            cmod_nxt    = '0;
            amod_nxt    = '0;
          end else begin
            // measure ends: compare against the top of the stack
            skip_nxt       = !is_newline;
            out_kind_nxt   = ilt_pkg::KIND_SAME;
            out_count_nxt  = '0;
            out_status_nxt = ilt_pkg::STAT_OK;
            out_depth_nxt  = ilt_pkg::DEPTH_W'(level_r);
            if (column_r == top_col_r) begin
              out_valid_nxt  = 1'b1;
              out_status_nxt = (alt_col_r != top_alt_r) ? ilt_pkg::STAT_ALT_SAME
                                                        : ilt_pkg::STAT_OK;
            end else if (column_r > top_col_r) begin
              out_valid_nxt = 1'b1;
              if (level_r == TOP_LEVEL) begin
                out_status_nxt = ilt_pkg::STAT_TOO_DEEP;
              end else if (alt_col_r <= top_alt_r) begin
                out_status_nxt = ilt_pkg::STAT_ALT_NOT_DEEPER;
              end else begin
                ram_we        = 1'b1;
                level_nxt     = level_r + 1'b1;
                top_col_nxt   = column_r;
                top_alt_nxt   = alt_col_r;
                out_kind_nxt  = ilt_pkg::KIND_INDENT;
                out_count_nxt = ilt_pkg::COUNT_W'(1);
                out_depth_nxt = ilt_pkg::DEPTH_W'(level_r + 1'b1);
              end
            end else begin
              // shallower: level_r is nonzero here since entry zero is column 0
              ram_re      = 1'b1;
              lv_nxt      = level_r - 1'b1;
              rd_zero_nxt = (level_r == AW'(1));
              state_nxt   = ilt_pkg::ST_POP;
            end
            if (state_nxt == ilt_pkg::ST_ACCEPT) begin
              column_nxt  = '0;
              alt_col_nxt = '0;
              cmod_nxt    = '0;
              amod_nxt    = '0;
            end
          end
        end
      end

      ilt_pkg::ST_POP: begin
        // lv_r has been popped to; its entry is on the read port
        if (!rd_zero_r && (column_r < rd_col)) begin
          ram_re      = 1'b1;
          ram_raddr   = lv_r - 1'b1;
          lv_nxt      = lv_r - 1'b1;
          rd_zero_nxt = (lv_r == AW'(1));
        end else begin
          level_nxt     = lv_r;
          top_col_nxt   = rd_col;
          top_alt_nxt   = rd_alt;
          out_valid_nxt = 1'b1;
          out_kind_nxt  = ilt_pkg::KIND_DEDENT;
          out_count_nxt = ilt_pkg::COUNT_W'(level_r - lv_r);
          out_depth_nxt = ilt_pkg::DEPTH_W'(lv_r);
          if (column_r != rd_col) begin
            out_status_nxt = ilt_pkg::STAT_NO_MATCH;
          end else if (alt_col_r != rd_alt) begin
            out_status_nxt = ilt_pkg::STAT_ALT_DEDENT;
          end else begin
            out_status_nxt = ilt_pkg::STAT_OK;
          end
          column_nxt  = '0;
          alt_col_nxt = '0;
          cmod_nxt    = '0;
          amod_nxt    = '0;
          state_nxt   = ilt_pkg::ST_ACCEPT;
        end
      end

      default: begin
        state_nxt = ilt_pkg::ST_ACCEPT;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ilt_pkg::ST_ACCEPT;
      column_r    <= '0;
      alt_col_r   <= '0;
      cmod_r      <= '0;
      amod_r      <= '0;
      skip_r      <= 1'b0;
      level_r     <= '0;
      top_col_r   <= '0;
      top_alt_r   <= '0;
      lv_r        <= '0;
      rd_zero_r   <= 1'b1;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      column_r    <= column_nxt;
      alt_col_r   <= alt_col_nxt;
      cmod_r      <= cmod_nxt;
      amod_r      <= amod_nxt;
      skip_r      <= skip_nxt;
      level_r     <= level_nxt;
      top_col_r   <= top_col_nxt;
      top_alt_r   <= top_alt_nxt;
      lv_r        <= lv_nxt;
      rd_zero_r   <= rd_zero_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // result payload, no reset needed
  always_ff @(posedge clk) begin
    out_kind_r   <= out_kind_nxt;
    out_count_r  <= out_count_nxt;
    out_status_r <= out_status_nxt;
    out_depth_r  <= out_depth_nxt;
  end

  assign out_tvalid = out_valid_r;
  assign out_tuser  = out_kind_r;
  assign out_tdata  = {out_depth_r, out_status_r, out_count_r};

endmodule

/* rtl/ilt_checker.sv */
// Port-level checker for the indentation level tracker, bound to the top level.
`include "assert_macros.svh"

module ilt_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        in_tvalid,
  input logic        in_tready,
  input logic [15:0] out_tdata,
  input logic [1:0]  out_tuser,
  input logic        out_tvalid,
  input logic        out_tready
);

  logic [6:0] chk_count;
  logic [2:0] chk_status;

  assign chk_count  = out_tdata[6:0];
  assign chk_status = out_tdata[9:7];

  // a stalled result holds
  `ASSERT_NEXT(a_out_hold, clk, rst_n, out_tvalid && !out_tready, out_tvalid && $stable(out_tdata) && $stable(out_tuser))

  // an indent opens exactly one level and is always clean
  `ASSERT_IMPL(a_indent_one, clk, rst_n, out_tvalid && (out_tuser == ilt_pkg::KIND_INDENT), (chk_count == 7'd1) && (chk_status == ilt_pkg::STAT_OK))

  // a same-level result never moves the stack
  `ASSERT_IMPL(a_same_zero, clk, rst_n, out_tvalid && (out_tuser == ilt_pkg::KIND_SAME), chk_count == 7'd0)

  // a dedent closes at least one level and reports only dedent statuses
  `ASSERT_IMPL(a_dedent_status, clk, rst_n, out_tvalid && (out_tuser == ilt_pkg::KIND_DEDENT), (chk_count != 7'd0) && ((chk_status == ilt_pkg::STAT_OK) || (chk_status == ilt_pkg::STAT_NO_MATCH) || (chk_status == ilt_pkg::STAT_ALT_DEDENT)))

  // input is held off while a result waits and is not taken
  `ASSERT_IMPL(a_no_overrun, clk, rst_n, out_tvalid && !out_tready, !in_tready)

endmodule

bind indent_level_tracker_core ilt_checker u_ilt_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_tvalid  (in_tvalid),
  .in_tready  (in_tready),
  .out_tdata  (out_tdata),
  .out_tuser  (out_tuser),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready)
);
